// ===== hw/rtl/tgard_pkg.sv =====
// Package: types and constants shared by the TGA RLE decoder files.
package tgard_pkg;

	localparam logic [4:0] HDR_IDX_TYPE   = 5'd2;
	localparam logic [4:0] HDR_IDX_W_LO   = 5'd12;
	localparam logic [4:0] HDR_IDX_W_HI   = 5'd13;
	localparam logic [4:0] HDR_IDX_H_LO   = 5'd14;
	localparam logic [4:0] HDR_IDX_H_HI   = 5'd15;
	localparam logic [4:0] HDR_IDX_DEPTH  = 5'd16;
	localparam logic [4:0] HDR_IDX_LAST   = 5'd17;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_SIZE = 2'd1;
	localparam logic [1:0] ST_BAD_TYPE = 2'd2;

	localparam logic [7:0] TYPE_RAW_COLOUR = 8'd2;
	localparam logic [7:0] TYPE_RAW_GREY   = 8'd3;
	localparam logic [7:0] TYPE_RLE_COLOUR = 8'd10;
	localparam logic [7:0] TYPE_RLE_GREY   = 8'd11;

	localparam logic [4:0] DEPTH_1B = 5'd1;
	localparam logic [4:0] DEPTH_3B = 5'd3;
	localparam logic [4:0] DEPTH_4B = 5'd4;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_RAW,
		PH_PKT_HDR,
		PH_PKT_DATA,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		SEQ_IN,
		SEQ_EXEC,
		SEQ_RUN
	} seq_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} tgard_in_t;

	typedef struct packed {
		logic        is_header;
		logic [1:0]  status;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [4:0]  bytes_per_pixel;
		logic [31:0] pixel_first;
		logic [31:0] pixel_second;
		logic [1:0]  pixels_in_beat;
		logic        last_pixel;
	} tgard_out_t;

endpackage

// ===== hw/rtl/tgard_stream_if.sv =====
// Interface: valid/ready stream channel with a typed payload.
interface tgard_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/tga_rle_image_decoder.sv =====
// Top level: TGA byte-stream decoder, header parse plus raw and RLE pixel output.
//
// Usage: file bytes enter on the bytes channel (tgard_in_t), one beat per byte;
// start_of_file marks header byte 0 and restarts parsing at any point.
// Results leave on the results channel (tgard_out_t): one header beat after
// the 18th header byte, then pixel beats carrying one or two pixels each.
// Each byte is captured into byte_q in SEQ_IN, then the sequencer applies it in
// SEQ_EXEC through the shared pixel-count decrementer. A run packet then moves on
// to SEQ_RUN and emits its beats there, so a run of n pixels adds ceil(n/2) beats.
// A result is registered and shows on results from the result register.
// bytes.ready is low while a byte or a run is being worked on. If the receiver
// stalls, the result register holds and the sequencer waits before producing
// the next beat; no result is dropped.
// After reset the block expects header byte 0. After a bad header or the last
// pixel, bytes are ignored until one arrives with start_of_file set.
module tga_rle_image_decoder (
	input logic                 clk,
	input logic                 arst_n,
	tgard_stream_if.sink        bytes,
	tgard_stream_if.source      results
);
	import tgard_pkg::*;

	seq_t        seq_q, seq_d;
	phase_t      phase_q, phase_d;
	logic [4:0]  hdr_idx_q, hdr_idx_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [4:0]  depth_q, depth_d;
	logic [7:0]  type_q, type_d;
	logic [31:0] pix_left_q, pix_left_d;
	logic [7:0]  pkt_left_q, pkt_left_d;
	logic        pkt_run_q, pkt_run_d;
	logic [31:0] asm_q, asm_d;
	logic [1:0]  bip_q, bip_d;
	logic [31:0] held_q, held_d;
	logic        held_vld_q, held_vld_d;
	logic [31:0] run_pix_q, run_pix_d;
	logic [7:0]  byte_q;
	logic        sof_q;
	tgard_out_t  out_q, out_d;
	logic        out_vld_q;

	logic        out_free;
	logic        emit;
	logic        start_run;
	logic        run_end;
	logic [1:0]  dec_amt;
	logic [31:0] pl_dec;

	assign out_free = !out_vld_q || results.ready;
	assign dec_amt  = (seq_q == SEQ_RUN && pkt_left_q >= 8'd2) ? 2'd2 : 2'd1;
	assign pl_dec   = pix_left_q - {30'd0, dec_amt};

	// datapath
	always_comb begin
		phase_t      ph;
		logic [4:0]  idx;
		logic [15:0] w;
		logic [15:0] h;
		logic [4:0]  dep;
		logic [7:0]  typ;
		logic [1:0]  st;
		logic [31:0] asm_n;
		logic        pix_done;
		logic [31:0] p;
		logic        fin;
		logic        do_push;
		logic [7:0]  kl;

		phase_d    = phase_q;
		hdr_idx_d  = hdr_idx_q;
		width_d    = width_q;
		height_d   = height_q;
		depth_d    = depth_q;
		type_d     = type_q;
		pix_left_d = pix_left_q;
		pkt_left_d = pkt_left_q;
		pkt_run_d  = pkt_run_q;
		asm_d      = asm_q;
		bip_d      = bip_q;
		held_d     = held_q;
		held_vld_d = held_vld_q;
		run_pix_d  = run_pix_q;
		out_d      = '0;
		emit       = 1'b0;
		start_run  = 1'b0;
		run_end    = 1'b0;
		st         = ST_OK;
		p          = '0;
		fin        = 1'b0;
		do_push    = 1'b0;
		kl         = pkt_left_q - {6'd0, dec_amt};

		ph  = sof_q ? PH_HEADER : phase_q;
		idx = sof_q ? 5'd0 : hdr_idx_q;
		w   = sof_q ? 16'd0 : width_q;
		h   = sof_q ? 16'd0 : height_q;
		dep = sof_q ? 5'd0 : depth_q;
		typ = sof_q ? 8'd0 : type_q;

		asm_n    = asm_q | ({24'd0, byte_q} << {bip_q, 3'b000});
		pix_done = ({3'd0, bip_q} + 5'd1) >= depth_q;

		if (seq_q == SEQ_EXEC && out_free) begin
			phase_d   = ph;
			hdr_idx_d = idx;
			width_d   = w;
			height_d  = h;
			depth_d   = dep;
			type_d    = typ;
			case (ph)
				PH_HEADER: begin
					case (idx)
						HDR_IDX_TYPE:  type_d = byte_q;
						HDR_IDX_W_LO:  width_d[7:0] = byte_q;
						HDR_IDX_W_HI:  width_d[15:8] = byte_q;
						HDR_IDX_H_LO:  height_d[7:0] = byte_q;
						HDR_IDX_H_HI:  height_d[15:8] = byte_q;
						HDR_IDX_DEPTH: depth_d = byte_q[7:3];
						default: ;
					endcase
					hdr_idx_d = idx + 5'd1;
					if (idx == HDR_IDX_LAST) begin
						if (width_q == 16'd0 || height_q == 16'd0 ||
						    !(depth_q inside {DEPTH_1B, DEPTH_3B, DEPTH_4B}))
							st = ST_BAD_SIZE;
						else if (!(type_q inside {TYPE_RAW_COLOUR, TYPE_RAW_GREY,
						                          TYPE_RLE_COLOUR, TYPE_RLE_GREY}))
							st = ST_BAD_TYPE;
						emit                  = 1'b1;
						out_d.is_header       = 1'b1;
						out_d.status          = st;
						out_d.image_width     = width_q;
						out_d.image_height    = height_q;
						out_d.bytes_per_pixel = depth_q;
						hdr_idx_d  = 5'd0;
						asm_d      = '0;
						bip_d      = '0;
						held_vld_d = 1'b0;
						if (st != ST_OK) begin
							phase_d = PH_DONE;
						end else begin
							pix_left_d = 32'(width_q) * 32'(height_q);
							phase_d = (type_q <= TYPE_RAW_GREY) ? PH_RAW : PH_PKT_HDR;
						end
					end
				end
				PH_RAW: begin
					asm_d = asm_n;
					bip_d = pix_done ? 2'd0 : bip_q + 2'd1;
					if (pix_done) begin
						p          = asm_n;
						asm_d      = '0;
						pix_left_d = pl_dec;
						fin        = (pl_dec == 32'd0);
						do_push    = 1'b1;
						if (pl_dec == 32'd0)
							phase_d = PH_DONE;
					end
				end
				PH_PKT_HDR: begin
					pkt_run_d  = byte_q[7];
					pkt_left_d = {1'b0, byte_q[6:0]} + 8'd1;
					asm_d      = '0;
					bip_d      = '0;
					held_vld_d = 1'b0;
					phase_d    = PH_PKT_DATA;
				end
				PH_PKT_DATA: begin
					asm_d = asm_n;
					bip_d = pix_done ? 2'd0 : bip_q + 2'd1;
					if (pix_done) begin
						asm_d = '0;
						if (pkt_run_q) begin
							pkt_left_d = ({24'd0, pkt_left_q} < pix_left_q) ?
								pkt_left_q : pix_left_q[7:0];
							run_pix_d  = asm_n;
							start_run  = 1'b1;
						end else begin
							p          = asm_n;
							pkt_left_d = kl;
							pix_left_d = pl_dec;
							fin        = (kl == 8'd0) || (pl_dec == 32'd0);
							do_push    = 1'b1;
							if (pl_dec == 32'd0)
								phase_d = PH_DONE;
							else if (kl == 8'd0)
								phase_d = PH_PKT_HDR;
						end
					end
				end
				default: ;
			endcase

			if (do_push) begin
				if (held_vld_q) begin
					emit                 = 1'b1;
					held_vld_d           = 1'b0;
					out_d.pixel_first    = held_q;
					out_d.pixel_second   = p;
					out_d.pixels_in_beat = 2'd2;
					out_d.last_pixel     = (pl_dec == 32'd0);
				end else if (fin) begin
					emit                 = 1'b1;
					out_d.pixel_first    = p;
					out_d.pixels_in_beat = 2'd1;
					out_d.last_pixel     = (pl_dec == 32'd0);
				end else begin
					held_d     = p;
					held_vld_d = 1'b1;
				end
			end
		end

		if (seq_q == SEQ_RUN && out_free) begin
			emit                 = 1'b1;
			out_d.pixel_first    = run_pix_q;
			out_d.pixel_second   = (dec_amt == 2'd2) ? run_pix_q : 32'd0;
			out_d.pixels_in_beat = dec_amt;
			out_d.last_pixel     = (pl_dec == 32'd0);
			pix_left_d           = pl_dec;
			pkt_left_d           = kl;
			if (kl == 8'd0) begin
				run_end = 1'b1;
				phase_d = (pl_dec == 32'd0) ? PH_DONE : PH_PKT_HDR;
			end
		end
	end

	// sequencer next state
	always_comb begin
		seq_d = seq_q;
		case (seq_q)
			SEQ_IN:   if (bytes.valid) seq_d = SEQ_EXEC;
			SEQ_EXEC: if (out_free) seq_d = start_run ? SEQ_RUN : SEQ_IN;
			SEQ_RUN:  if (out_free && run_end) seq_d = SEQ_IN;
			default:  seq_d = SEQ_IN;
		endcase
	end

	// sequencer outputs
	always_comb begin
		bytes.ready     = (seq_q == SEQ_IN);
		results.valid   = out_vld_q;
		results.payload = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= SEQ_IN;
			phase_q    <= PH_HEADER;
			hdr_idx_q  <= '0;
			width_q    <= '0;
			height_q   <= '0;
			depth_q    <= '0;
			type_q     <= '0;
			pix_left_q <= '0;
			pkt_left_q <= '0;
			pkt_run_q  <= 1'b0;
			asm_q      <= '0;
			bip_q      <= '0;
			held_q     <= '0;
			held_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			seq_q      <= seq_d;
			phase_q    <= phase_d;
			hdr_idx_q  <= hdr_idx_d;
			width_q    <= width_d;
			height_q   <= height_d;
			depth_q    <= depth_d;
			type_q     <= type_d;
			pix_left_q <= pix_left_d;
			pkt_left_q <= pkt_left_d;
			pkt_run_q  <= pkt_run_d;
			asm_q      <= asm_d;
			bip_q      <= bip_d;
			held_q     <= held_d;
			held_vld_q <= held_vld_d;
			if (emit)
				out_vld_q <= 1'b1;
			else if (results.ready)
				out_vld_q <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		run_pix_q <= run_pix_d;
		if (bytes.valid && bytes.ready) begin
			byte_q <= bytes.payload.data_byte;
			sof_q  <= bytes.payload.start_of_file;
		end
		if (emit)
			out_q <= out_d;
	end

endmodule

// ===== verif/tb_tga_rle_image_decoder.sv =====
// Testbench for the TGA RLE decoder: random byte streams, predicted beats checked in order.
module tb_tga_rle_image_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import tgard_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic      hold_idle;
		tgard_in_t beat;
	} feed_t;

	logic clk;
	logic arst_n;

	tgard_stream_if #(.T(tgard_in_t))  byte_ch ();
	tgard_stream_if #(.T(tgard_out_t)) result_ch ();

	tga_rle_image_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch),
		.results (result_ch)
	);

	always #6ns clk = ~clk;

	feed_t      byte_feed[$];
	tgard_out_t decoded_beats[$];
	int         fed_bytes = 0;
	int         fault_cnt = 0;
	int         cycle_cnt = 0;
	int         gap_left = 0;
	int         burst_left = 4;
	int         quiet_cnt = 0;
	int         rx_tick = 0;
	int         rx_mode = 0;

	// decoder mirror
	phase_t      dec_phase;
	logic [4:0]  hdr_idx;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [4:0]  depth_q;
	logic [7:0]  type_q;
	logic [31:0] pix_left;
	logic [7:0]  pkt_left;
	logic        pkt_run;
	logic [31:0] pix_acc;
	logic [1:0]  byte_idx;
	logic [31:0] held_pix;
	logic        held_ok;

	function automatic void clear_decoder();
		dec_phase = PH_HEADER;
		hdr_idx   = '0;
		width_q   = '0;
		height_q  = '0;
		depth_q   = '0;
		type_q    = '0;
		pix_left  = '0;
		pkt_left  = '0;
		pkt_run   = 1'b0;
		pix_acc   = '0;
		byte_idx  = '0;
		held_pix  = '0;
		held_ok   = 1'b0;
	endfunction

	function automatic void emit_pixels(logic [31:0] a, logic [31:0] b, logic [1:0] cnt);
		tgard_out_t r;
		r = '0;
		r.pixel_first    = a;
		r.pixel_second   = (cnt == 2'd2) ? b : '0;
		r.pixels_in_beat = cnt;
		r.last_pixel     = (pix_left == 0);
		decoded_beats.push_back(r);
	endfunction

	// fin: pixel closes its pairing group
	function automatic void pair_pixel(logic [31:0] p, logic fin);
		if (held_ok) begin
			held_ok = 1'b0;
			emit_pixels(held_pix, p, 2'd2);
		end else if (fin) begin
			emit_pixels(p, '0, 2'd1);
		end else begin
			held_pix = p;
			held_ok  = 1'b1;
		end
	endfunction

	function automatic logic gather_byte(logic [7:0] b);
		pix_acc = pix_acc | (32'(b) << (8 * byte_idx));
		if (32'(byte_idx) + 1 >= 32'(depth_q)) begin
			byte_idx = '0;
			return 1'b1;
		end
		byte_idx = byte_idx + 2'd1;
		return 1'b0;
	endfunction

	function automatic void decode_byte(tgard_in_t in_beat);
		logic [7:0]  b;
		logic [31:0] px;
		logic [1:0]  st;
		tgard_out_t  hdr;
		int          n;
		b = in_beat.data_byte;
		if (in_beat.start_of_file)
			clear_decoder();
		case (dec_phase)
			PH_HEADER: begin
				case (hdr_idx)
					HDR_IDX_TYPE:  type_q = b;
					HDR_IDX_W_LO:  width_q[7:0] = b;
					HDR_IDX_W_HI:  width_q[15:8] = b;
					HDR_IDX_H_LO:  height_q[7:0] = b;
					HDR_IDX_H_HI:  height_q[15:8] = b;
					HDR_IDX_DEPTH: depth_q = b[7:3];
					default: ;
				endcase
				if (hdr_idx == HDR_IDX_LAST) begin
					if (width_q == 0 || height_q == 0 ||
					    !(depth_q inside {DEPTH_1B, DEPTH_3B, DEPTH_4B}))
						st = ST_BAD_SIZE;
					else if (!(type_q inside {TYPE_RAW_COLOUR, TYPE_RAW_GREY,
					                          TYPE_RLE_COLOUR, TYPE_RLE_GREY}))
						st = ST_BAD_TYPE;
					else
						st = ST_OK;
					hdr = '0;
					hdr.is_header       = 1'b1;
					hdr.status          = st;
					hdr.image_width     = width_q;
					hdr.image_height    = height_q;
					hdr.bytes_per_pixel = depth_q;
					decoded_beats.push_back(hdr);
					hdr_idx  = '0;
					pix_acc  = '0;
					byte_idx = '0;
					held_ok  = 1'b0;
					if (st != ST_OK) begin
						dec_phase = PH_DONE;
					end else begin
						pix_left  = 32'(width_q) * 32'(height_q);
						dec_phase = (type_q <= TYPE_RAW_GREY) ? PH_RAW : PH_PKT_HDR;
					end
				end else begin
					hdr_idx = hdr_idx + 5'd1;
				end
			end
			PH_RAW: begin
				if (gather_byte(b)) begin
					px       = pix_acc;
					pix_acc  = '0;
					pix_left = pix_left - 1;
					pair_pixel(px, pix_left == 0);
					if (pix_left == 0)
						dec_phase = PH_DONE;
				end
			end
			PH_PKT_HDR: begin
				pkt_run   = b[7];
				pkt_left  = {1'b0, b[6:0]} + 8'd1;
				pix_acc   = '0;
				byte_idx  = '0;
				held_ok   = 1'b0;
				dec_phase = PH_PKT_DATA;
			end
			PH_PKT_DATA: begin
				if (gather_byte(b)) begin
					px      = pix_acc;
					pix_acc = '0;
					if (pkt_run) begin
						n = (32'(pkt_left) < pix_left) ? int'(pkt_left) : int'(pix_left);
						for (int j = 0; j < n; j++) begin
							pix_left = pix_left - 1;
							pair_pixel(px, j + 1 == n);
						end
						pkt_left = '0;
					end else begin
						pkt_left = pkt_left - 8'd1;
						pix_left = pix_left - 1;
						pair_pixel(px, pkt_left == 0 || pix_left == 0);
					end
					if (pix_left == 0)
						dec_phase = PH_DONE;
					else if (pkt_left == 0)
						dec_phase = PH_PKT_HDR;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic string beat_text(tgard_out_t r);
		return $sformatf("hdr=%0b st=%0d w=%0d h=%0d bpp=%0d p0=%08h p1=%08h n=%0d last=%0b",
			r.is_header, r.status, r.image_width, r.image_height, r.bytes_per_pixel,
			r.pixel_first, r.pixel_second, r.pixels_in_beat, r.last_pixel);
	endfunction

	function automatic void log_fault(string what, tgard_out_t want, tgard_out_t got);
		if (fault_cnt < 10)
			$display("%0t %s\n  exp: %s\n  got: %s", $realtime, what,
				beat_text(want), beat_text(got));
		fault_cnt++;
	endfunction

	task automatic add_byte(logic [7:0] v, logic sof, logic hold);
		feed_t f;
		f.hold_idle            = hold;
		f.beat.data_byte       = v;
		f.beat.start_of_file   = sof;
		byte_feed.push_back(f);
		fed_bytes++;
	endtask

	task automatic add_noise(int n);
		for (int i = 0; i < n; i++)
			add_byte(8'($urandom), 1'b0, 1'b0);
	endtask

	task automatic add_header(logic sof, logic hold, logic [7:0] typ, logic [15:0] w,
	                          logic [15:0] h, logic [7:0] dep, int stop_at);
		logic [7:0] v;
		for (int i = 0; i < stop_at; i++) begin
			v = 8'($urandom);
			case (5'(i))
				HDR_IDX_TYPE:  v = typ;
				HDR_IDX_W_LO:  v = w[7:0];
				HDR_IDX_W_HI:  v = w[15:8];
				HDR_IDX_H_LO:  v = h[7:0];
				HDR_IDX_H_HI:  v = h[15:8];
				HDR_IDX_DEPTH: v = dep;
				default: ;
			endcase
			add_byte(v, (i == 0) ? sof : 1'b0, (i == 0) ? hold : 1'b0);
		end
	endtask

	// packets until the image is covered or the byte budget runs out
	task automatic add_packets(longint unsigned npix, int dbytes, int budget);
		longint unsigned covered;
		int              cnt;
		logic            is_run;
		covered = 0;
		while (covered < npix && budget > 0) begin
			is_run = 1'($urandom_range(0, 1));
			cnt = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
			if (!is_run && cnt > 6 && npix - covered > 6)
				cnt = $urandom_range(1, 6);
			add_byte({is_run, 7'(cnt - 1)}, 1'b0, 1'b0);
			if (is_run)
				add_noise(dbytes);
			else if (npix - covered < longint'(cnt))
				add_noise(int'(npix - covered) * dbytes);
			else
				add_noise(cnt * dbytes);
			covered += cnt;
			budget -= 1 + dbytes;
		end
	endtask

	// sender: bursts and gaps, optional hold until the results have drained
	always @(posedge clk) begin
		feed_t nxt;
		if (arst_n) begin
			if (!byte_ch.valid || byte_ch.ready) begin
				if (gap_left != 0) begin
					gap_left      <= gap_left - 1;
					byte_ch.valid <= 1'b0;
				end else if (byte_feed.size() == 0) begin
					byte_ch.valid <= 1'b0;
				end else if (byte_feed[0].hold_idle && quiet_cnt < 6) begin
					byte_ch.valid <= 1'b0;
					quiet_cnt     <= (decoded_beats.size() == 0) ? quiet_cnt + 1 : 0;
				end else begin
					nxt              = byte_feed.pop_front();
					byte_ch.valid   <= 1'b1;
					byte_ch.payload <= nxt.beat;
					quiet_cnt       <= 0;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 16);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// prediction, checking and receiver stalls
	always @(posedge clk) begin
		tgard_out_t want;
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready)
				decode_byte(byte_ch.payload);
			if (result_ch.valid && result_ch.ready) begin
				if (decoded_beats.size() == 0) begin
					log_fault("unexpected beat", '0, result_ch.payload);
				end else begin
					want = decoded_beats.pop_front();
					if (result_ch.payload !== want)
						log_fault("beat mismatch", want, result_ch.payload);
				end
			end
			rx_tick <= rx_tick + 1;
			if (rx_tick % 128 == 127)
				rx_mode <= $urandom_range(0, 2);
			case (rx_mode)
				0:       result_ch.ready <= 1'b1;
				1:       result_ch.ready <= 1'($urandom_range(0, 1));
				default: result_ch.ready <= (rx_tick % 7) >= 4;
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int              sel;
		int              files;
		int              dbytes;
		logic            hold;
		logic            cut;
		logic [15:0]     w;
		logic [15:0]     h;
		logic [7:0]      typ;
		logic [7:0]      dep;
		longint unsigned npix;
		longint unsigned nsend;

		clk               = 1'b0;
		arst_n            = 1'b0;
		byte_ch.valid     = 1'b0;
		byte_ch.payload   = '0;
		result_ch.ready   = 1'b0;
		clear_decoder();

		// first file without a start mark; run pair, then a raw packet clipped at the end
		add_header(1'b0, 1'b0, TYPE_RLE_COLOUR, 16'd3, 16'd1, 8'h0F, 18);
		add_byte(8'h81, 1'b0, 1'b0);
		add_byte(8'hFF, 1'b0, 1'b0);
		add_byte(8'h01, 1'b0, 1'b0);
		add_byte(8'h00, 1'b0, 1'b0);
		add_byte(8'hA5, 1'b0, 1'b0);

		files = 0;
		while (fed_bytes < 250) begin
			sel  = $urandom_range(0, 99);
			hold = (files == 0) || ($urandom_range(0, 6) == 0);
			cut  = (sel >= 90);
			files++;
			case ($urandom_range(0, 9))
				7: begin
					w = 16'($urandom_range(1, 300));
					h = 16'd1;
				end
				8: begin
					w = 16'hFFFF;
					h = 16'($urandom_range(1, 65535));
				end
				9: begin
					w = 16'($urandom_range(1, 65535));
					h = 16'hFFFF;
				end
				default: begin
					w = 16'($urandom_range(1, 5));
					h = 16'($urandom_range(1, 3));
				end
			endcase
			case ($urandom_range(0, 2))
				0:       dbytes = int'(DEPTH_1B);
				1:       dbytes = int'(DEPTH_3B);
				default: dbytes = int'(DEPTH_4B);
			endcase
			dep = {5'(dbytes), 3'($urandom)};
			case ($urandom_range(0, 3))
				0:       typ = TYPE_RAW_COLOUR;
				1:       typ = TYPE_RAW_GREY;
				2:       typ = TYPE_RLE_COLOUR;
				default: typ = TYPE_RLE_GREY;
			endcase

			if (sel >= 60 && sel < 70) begin
				typ = 8'($urandom);
				case ($urandom_range(0, 2))
					0: w = '0;
					1: h = '0;
					default: begin
						do dep = 8'($urandom);
						while (dep[7:3] inside {DEPTH_1B, DEPTH_3B, DEPTH_4B});
					end
				endcase
				add_header(1'b1, hold, typ, w, h, dep, 18);
				add_noise($urandom_range(0, 3));
			end else if (sel >= 70 && sel < 80) begin
				do typ = 8'($urandom);
				while (typ inside {TYPE_RAW_COLOUR, TYPE_RAW_GREY,
				                   TYPE_RLE_COLOUR, TYPE_RLE_GREY});
				add_header(1'b1, hold, typ, w, h, dep, 18);
				add_noise($urandom_range(0, 3));
			end else if (sel >= 80 && sel < 90) begin
				add_header(1'b1, hold, typ, w, h, dep, $urandom_range(1, 17));
			end else begin
				add_header(1'b1, hold, typ, w, h, dep, 18);
				npix = longint'(w) * longint'(h);
				if (typ <= TYPE_RAW_GREY) begin
					nsend = (npix < 12) ? npix : 12;
					if (cut)
						nsend = $urandom_range(0, int'(nsend) - 1);
					add_noise(int'(nsend) * dbytes + (cut ? $urandom_range(0, dbytes - 1) : 0));
				end else begin
					add_packets(npix, dbytes, cut ? $urandom_range(1, 4) : 40);
				end
				if (!cut)
					add_noise($urandom_range(0, 2));
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (byte_feed.size() != 0 || byte_ch.valid)
			@(posedge clk);
		while (decoded_beats.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		if (fault_cnt == 0 && decoded_beats.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
